@@ rtl/acdp_pkg.sv @@
package acdp_pkg;

    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int CFG_AW           = 5;
    localparam int DIV_STEPS        = 5;   // byte digits of the 40-bit dividend

    typedef enum logic [2:0] {
        REG_MAX_REF_GAP   = 3'd0,
        REG_MAX_QUERY_GAP = 3'd1,
        REG_BAND_WIDTH    = 3'd2,
        REG_SKIP_LIMIT    = 3'd3,
        REG_ITER_LIMIT    = 3'd4,
        REG_SPLICE_MODE   = 3'd5,
        REG_MULTI_SEGMENT = 3'd6,
        REG_AVG_SPAN_Q8   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic        read_start;
        logic [31:0] ref_tag;
        logic [31:0] ref_pos;
        logic [30:0] query_pos;
        logic [7:0]  span;
        logic [7:0]  segment_id;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] chain_score;
        logic signed [31:0] predecessor;
        logic signed [31:0] peak_score;
    } t_out_item;

    typedef struct packed {
        logic [15:0] max_ref_gap;
        logic [15:0] max_query_gap;
        logic [15:0] band_width;
        logic [7:0]  skip_limit;
        logic [6:0]  iter_limit;
        logic        splice_mode;
        logic        multi_segment;
        logic [15:0] avg_span_q8;
    } t_cfg;

    typedef struct packed {
        logic [31:0]        ref_pos;
        logic [30:0]        query_pos;
        logic [7:0]         segment;
        logic signed [31:0] score;
        logic [31:0]        pred;
        logic               pred_valid;
        logic signed [31:0] peak;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SETUP, ST_WALK_RD, ST_WALK_CHK, ST_LIMIT, ST_SCAN_RD,
        ST_EVAL1, ST_EVAL2, ST_MUL, ST_DIV, ST_COST, ST_SUM, ST_UPD,
        ST_PEAK_RD, ST_PEAK_CHK, ST_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic clamp_depth;
        logic walk_rd;
        logic walk_adv;
        logic clamp_lim;
        logic scan_rd;
        logic eval1;
        logic eval2;
        logic mul;
        logic skip_pred;
        logic div_step;
        logic cost;
        logic sum;
        logic upd;
        logic peak_rd;
        logic peak_chk;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic st_at_i;
        logic walk_go;
        logic scan_done;
        logic pass;
        logic brk;
        logic have_pred;
        logic out_free;
    } t_sts;

    // one radix-256 digit of a division by 25: {quotient digit, remainder}
    function automatic logic [12:0] div25_step(logic [4:0] rem, logic [7:0] digit);
        logic [12:0] v;
        logic [7:0]  q;
        v = {rem, digit};
        q = '0;
        for (int b = 7; b >= 0; b--) begin
            if (v >= (13'd25 << b)) begin
                v    = v - (13'd25 << b);
                q[b] = 1'b1;
            end
        end
        return {q, v[4:0]};
    endfunction

    function automatic logic [4:0] floor_log2(logic [31:0] v);
        logic [4:0] r;
        r = '0;
        for (int b = 1; b < 32; b++) begin
            if (v[b]) begin
                r = 5'(b);
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/acdp_ram.sv @@
module acdp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/acdp_regs.sv @@
module acdp_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [acdp_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output acdp_pkg::t_cfg             o_cfg
);
    import acdp_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;

    assign w_idx  = t_reg_idx'(paddr[CFG_AW-1:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_ref_gap   <= 16'd5000;
            r_cfg.max_query_gap <= 16'd5000;
            r_cfg.band_width    <= 16'd500;
            r_cfg.skip_limit    <= 8'd25;
            r_cfg.iter_limit    <= 7'd64;
            r_cfg.splice_mode   <= 1'b0;
            r_cfg.multi_segment <= 1'b0;
            r_cfg.avg_span_q8   <= 16'd3840;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_MAX_REF_GAP:   r_cfg.max_ref_gap   <= pwdata[15:0];
                REG_MAX_QUERY_GAP: r_cfg.max_query_gap <= pwdata[15:0];
                REG_BAND_WIDTH:    r_cfg.band_width    <= pwdata[15:0];
                REG_SKIP_LIMIT:    r_cfg.skip_limit    <= pwdata[7:0];
                REG_ITER_LIMIT:    r_cfg.iter_limit    <= pwdata[6:0];
                REG_SPLICE_MODE:   r_cfg.splice_mode   <= pwdata[0];
                REG_MULTI_SEGMENT: r_cfg.multi_segment <= pwdata[0];
                REG_AVG_SPAN_Q8:   r_cfg.avg_span_q8   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MAX_REF_GAP:   prdata = {16'd0, r_cfg.max_ref_gap};
            REG_MAX_QUERY_GAP: prdata = {16'd0, r_cfg.max_query_gap};
            REG_BAND_WIDTH:    prdata = {16'd0, r_cfg.band_width};
            REG_SKIP_LIMIT:    prdata = {24'd0, r_cfg.skip_limit};
            REG_ITER_LIMIT:    prdata = {25'd0, r_cfg.iter_limit};
            REG_SPLICE_MODE:   prdata = {31'd0, r_cfg.splice_mode};
            REG_MULTI_SEGMENT: prdata = {31'd0, r_cfg.multi_segment};
            REG_AVG_SPAN_Q8:   prdata = {16'd0, r_cfg.avg_span_q8};
            default:           prdata = '0;
        endcase
    end
endmodule

@@ rtl/acdp_ctrl.sv @@
module acdp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  acdp_pkg::t_sts i_sts,
    output acdp_pkg::t_cmd o_cmd
);
    import acdp_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_div_cnt, n_div_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_div_cnt  = r_div_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SETUP;
                end
            end
            ST_SETUP: begin
                o_cmd.clamp_depth = 1'b1;
                n_state           = ST_WALK_RD;
            end
            ST_WALK_RD: begin
                if (i_sts.st_at_i) begin
                    n_state = ST_LIMIT;
                end else begin
                    o_cmd.walk_rd = 1'b1;
                    n_state       = ST_WALK_CHK;
                end
            end
            ST_WALK_CHK: begin
                if (i_sts.walk_go) begin
                    o_cmd.walk_adv = 1'b1;
                    n_state        = ST_WALK_RD;
                end else begin
                    n_state = ST_LIMIT;
                end
            end
            ST_LIMIT: begin
                o_cmd.clamp_lim = 1'b1;
                n_state         = ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
                if (i_sts.scan_done) begin
                    n_state = ST_PEAK_RD;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state       = ST_EVAL1;
                end
            end
            ST_EVAL1: begin
                o_cmd.eval1 = 1'b1;
                n_state     = ST_EVAL2;
            end
            ST_EVAL2: begin
                o_cmd.eval2 = 1'b1;
                n_state     = ST_MUL;
            end
            ST_MUL: begin
                if (i_sts.pass) begin
                    o_cmd.mul = 1'b1;
                    n_div_cnt = '0;
                    n_state   = ST_DIV;
                end else begin
                    o_cmd.skip_pred = 1'b1;
                    n_state         = ST_SCAN_RD;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt + 3'd1;
                if (r_div_cnt == 3'(DIV_STEPS - 1)) begin
                    n_state = ST_COST;
                end
            end
            ST_COST: begin
                o_cmd.cost = 1'b1;
                n_state    = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = i_sts.brk ? ST_PEAK_RD : ST_SCAN_RD;
            end
            ST_PEAK_RD: begin
                if (i_sts.have_pred) begin
                    o_cmd.peak_rd = 1'b1;
                    n_state       = ST_PEAK_CHK;
                end else begin
                    n_state = ST_COMMIT;
                end
            end
            ST_PEAK_CHK: begin
                o_cmd.peak_chk = 1'b1;
                n_state        = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

@@ rtl/acdp_dp.sv @@
module acdp_dp #(
    parameter int WINDOW_DEPTH = acdp_pkg::WINDOW_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  acdp_pkg::t_cfg     i_cfg,
    input  acdp_pkg::t_in_item i_in_data,
    input  acdp_pkg::t_cmd     i_cmd,
    output acdp_pkg::t_sts     o_sts,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output acdp_pkg::t_out_item o_out_data
);
    import acdp_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [31:0] DEPTH32 = 32'(WINDOW_DEPTH);

    function automatic logic [AW-1:0] slot_inc(logic [AW-1:0] s);
        return (s == AW'(WINDOW_DEPTH - 1)) ? '0 : s + AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_dec(logic [AW-1:0] s);
        return (s == '0) ? AW'(WINDOW_DEPTH - 1) : s - AW'(1);
    endfunction

    // d never exceeds the depth here
    function automatic logic [AW-1:0] slot_back(logic [AW-1:0] s, logic [31:0] d);
        logic [31:0] s32;
        s32 = 32'(s);
        if (s32 >= d) begin
            return AW'(s32 - d);
        end
        return AW'(s32 + DEPTH32 - d);
    endfunction

    // persistent window state
    logic [31:0]   r_anchor_index, r_window_first, r_current_tag;
    logic [AW-1:0] r_first_slot, r_i_slot;

    // per-item state
    t_in_item           r_item;
    logic [31:0]        r_i, r_st, r_j, r_max_j;
    logic [AW-1:0]      r_st_slot, r_j_slot, r_maxj_slot;
    logic [CW-1:0]      r_left, r_n;
    logic signed [31:0] r_max_f, r_peak;
    logic               r_have_pred;
    logic [8:0]         r_nskip;

    // per-predecessor pipeline
    logic signed [32:0] r_dr;
    logic signed [31:0] r_dq;
    logic               r_same, r_mark_hit, r_wpv, r_pass, r_dr_gt_dq, r_dr_zero;
    logic signed [31:0] r_wscore;
    logic [31:0]        r_wpred, r_dd;
    logic signed [33:0] r_scb;
    logic [39:0]        r_pq, r_q;
    logic [4:0]         r_rem, r_clog;
    logic [34:0]        r_cost;
    logic               r_plus1;
    logic signed [37:0] r_sum;

    logic      r_out_valid;
    t_out_item r_out;

    // memories
    t_entry        w_rd_entry, w_wr_entry;
    logic [31:0]   w_rd_mark, w_mark_wdata;
    logic          w_ent_re, w_mark_we;
    logic [AW-1:0] w_ent_raddr, w_mark_waddr;

    acdp_ram #(.WIDTH($bits(t_entry)), .DEPTH(WINDOW_DEPTH)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (r_i_slot),
        .i_wdata (w_wr_entry),
        .i_re    (w_ent_re),
        .i_raddr (w_ent_raddr),
        .o_rdata (w_rd_entry)
    );

    acdp_ram #(.WIDTH(32), .DEPTH(WINDOW_DEPTH)) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (w_mark_we),
        .i_waddr (w_mark_waddr),
        .i_wdata (w_mark_wdata),
        .i_re    (i_cmd.scan_rd),
        .i_raddr (r_j_slot),
        .o_rdata (w_rd_mark)
    );

    assign w_ent_re = i_cmd.walk_rd || i_cmd.scan_rd || i_cmd.peak_rd;

    always_comb begin
        w_ent_raddr = r_j_slot;
        if (i_cmd.walk_rd) begin
            w_ent_raddr = r_st_slot;
        end else if (i_cmd.peak_rd) begin
            w_ent_raddr = r_maxj_slot;
        end
    end

    // setup arithmetic
    logic [31:0]        w_span_i, w_lim;
    logic [32:0]        w_ref_reach;
    // eval2 arithmetic
    logic signed [33:0] w_d1, w_d2, w_min_d, w_span_s;
    logic [33:0]        w_abs;
    logic               w_dq_pos, w_skip_a, w_skip_b, w_band_bad, w_multi_bad;
    // cost and update arithmetic
    logic [12:0]        w_div;
    logic [33:0]        w_clin;
    logic [34:0]        w_full_cost, w_min_cost;
    logic signed [31:0] w_sc;
    logic               w_gt, w_brk, w_mark_ok;
    logic [31:0]        w_pred_dist;
    logic [47:0]        w_prod;

    assign w_span_i    = r_i - r_st;
    assign w_lim       = ({25'd0, i_cfg.iter_limit} < DEPTH32) ?
                         {25'd0, i_cfg.iter_limit} : DEPTH32;
    assign w_ref_reach = {1'b0, w_rd_entry.ref_pos} + {17'd0, i_cfg.max_ref_gap};

    assign w_d1     = 34'(r_dr) - 34'(r_dq);
    assign w_d2     = 34'(r_dq) - 34'(r_dr);
    assign w_abs    = w_d1[33] ? w_d2 : w_d1;
    assign w_dq_pos = !r_dq[31] && (r_dq != '0);
    assign w_skip_a = (r_same && (r_dr == '0)) || !w_dq_pos;
    assign w_skip_b = (r_same && (r_dq > $signed({16'd0, i_cfg.max_query_gap}))) ||
                      (r_dq > $signed({16'd0, i_cfg.max_ref_gap}));
    assign w_band_bad  = r_same && (w_abs > {18'd0, i_cfg.band_width});
    assign w_multi_bad = i_cfg.multi_segment && !i_cfg.splice_mode && r_same &&
                         (r_dr > $signed({17'd0, i_cfg.max_query_gap}));
    assign w_min_d  = (34'(r_dq) < 34'(r_dr)) ? 34'(r_dq) : 34'(r_dr);
    assign w_span_s = $signed({26'd0, r_item.span});

    assign w_prod = r_dd * i_cfg.avg_span_q8;
    assign w_div  = div25_step(r_rem, r_pq[39:32]);

    assign w_clin      = r_q[33:0];
    assign w_full_cost = {1'b0, w_clin} + {31'd0, r_clog[4:1]};
    assign w_min_cost  = (w_clin < {29'd0, r_clog}) ? {1'b0, w_clin} : {30'd0, r_clog};

    always_comb begin
        if (r_sum > 38'sd2147483647) begin
            w_sc = 32'sh7fffffff;
        end else if (r_sum < -38'sd2147483648) begin
            w_sc = 32'sh80000000;
        end else begin
            w_sc = r_sum[31:0];
        end
    end

    assign w_gt        = w_sc > r_max_f;
    assign w_brk       = !w_gt && r_mark_hit && ((r_nskip + 9'd1) > {1'b0, i_cfg.skip_limit});
    assign w_pred_dist = r_i - r_wpred;
    assign w_mark_ok   = r_wpv && (w_pred_dist <= 32'(r_n));

    // mark predecessors of examined entries; clear the mark of a new entry
    assign w_mark_we    = (i_cmd.upd && !w_brk && w_mark_ok) || i_cmd.commit;
    assign w_mark_waddr = i_cmd.commit ? r_i_slot : slot_back(r_i_slot, w_pred_dist);
    assign w_mark_wdata = i_cmd.commit ? '0 : r_i;

    always_comb begin
        w_wr_entry.ref_pos    = r_item.ref_pos;
        w_wr_entry.query_pos  = r_item.query_pos;
        w_wr_entry.segment    = r_item.segment_id;
        w_wr_entry.score      = r_max_f;
        w_wr_entry.pred       = r_max_j;
        w_wr_entry.pred_valid = r_have_pred;
        w_wr_entry.peak       = r_have_pred ? r_peak : r_max_f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor_index <= '0;
            r_window_first <= '0;
            r_current_tag  <= '0;
            r_first_slot   <= '0;
            r_i_slot       <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (i_in_data.read_start) begin
                    r_i_slot      <= '0;
                    r_current_tag <= i_in_data.ref_tag;
                end else if (i_in_data.ref_tag != r_current_tag) begin
                    r_current_tag <= i_in_data.ref_tag;
                end
            end
            if (i_cmd.commit) begin
                r_anchor_index <= r_i + 32'd1;
                r_window_first <= r_st;
                r_first_slot   <= r_st_slot;
                r_i_slot       <= slot_inc(r_i_slot);
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
            if (i_in_data.read_start) begin
                r_i       <= '0;
                r_st      <= '0;
                r_st_slot <= '0;
            end else if (i_in_data.ref_tag != r_current_tag) begin
                r_i       <= r_anchor_index;
                r_st      <= r_anchor_index;
                r_st_slot <= r_i_slot;
            end else begin
                r_i       <= r_anchor_index;
                r_st      <= r_window_first;
                r_st_slot <= r_first_slot;
            end
        end
        if (i_cmd.clamp_depth && (w_span_i > DEPTH32)) begin
            r_st      <= r_i - DEPTH32;
            r_st_slot <= r_i_slot;
        end
        if (i_cmd.walk_adv) begin
            r_st      <= r_st + 32'd1;
            r_st_slot <= slot_inc(r_st_slot);
        end
        if (i_cmd.clamp_lim) begin
            if (w_span_i > w_lim) begin
                r_st      <= r_i - w_lim;
                r_st_slot <= slot_back(r_i_slot, w_lim);
                r_n       <= CW'(w_lim);
                r_left    <= CW'(w_lim);
            end else begin
                r_n    <= CW'(w_span_i);
                r_left <= CW'(w_span_i);
            end
            r_j         <= r_i - 32'd1;
            r_j_slot    <= slot_dec(r_i_slot);
            r_max_f     <= {24'd0, r_item.span};
            r_max_j     <= '0;
            r_maxj_slot <= '0;
            r_have_pred <= 1'b0;
            r_nskip     <= '0;
        end
        if (i_cmd.eval1) begin
            r_dr       <= $signed({1'b0, r_item.ref_pos}) - $signed({1'b0, w_rd_entry.ref_pos});
            r_dq       <= $signed({1'b0, r_item.query_pos}) -
                          $signed({1'b0, w_rd_entry.query_pos});
            r_same     <= w_rd_entry.segment == r_item.segment_id;
            r_wscore   <= w_rd_entry.score;
            r_wpred    <= w_rd_entry.pred;
            r_wpv      <= w_rd_entry.pred_valid;
            r_mark_hit <= w_rd_mark == r_i;
        end
        if (i_cmd.eval2) begin
            r_pass     <= !(w_skip_a || w_skip_b || w_band_bad || w_multi_bad);
            r_dd       <= (w_abs[33:32] != 2'b00) ? 32'hffffffff : w_abs[31:0];
            r_scb      <= (w_min_d > w_span_s) ? w_span_s : w_min_d;
            r_dr_gt_dq <= 34'(r_dr) > 34'(r_dq);
            r_dr_zero  <= r_dr == '0;
        end
        if (i_cmd.mul) begin
            // drop the low ten bits now: 25600 is 25 * 1024
            r_pq   <= {2'b00, w_prod[47:10]};
            r_q    <= '0;
            r_rem  <= '0;
            r_clog <= floor_log2(r_dd);
        end
        if (i_cmd.div_step) begin
            r_pq  <= {r_pq[31:0], 8'd0};
            r_q   <= {r_q[31:0], w_div[12:5]};
            r_rem <= w_div[4:0];
        end
        if (i_cmd.cost) begin
            r_plus1 <= 1'b0;
            if (i_cfg.splice_mode || !r_same) begin
                if (!r_same && r_dr_zero) begin
                    r_cost  <= '0;
                    r_plus1 <= 1'b1;
                end else if (r_dr_gt_dq || !r_same) begin
                    r_cost <= w_min_cost;
                end else begin
                    r_cost <= w_full_cost;
                end
            end else begin
                r_cost <= w_full_cost;
            end
        end
        if (i_cmd.sum) begin
            r_sum <= 38'(r_scb) - $signed({3'd0, r_cost}) + $signed({37'd0, r_plus1}) +
                     38'(r_wscore);
        end
        if (i_cmd.upd) begin
            if (w_gt) begin
                r_max_f     <= w_sc;
                r_max_j     <= r_j;
                r_maxj_slot <= r_j_slot;
                r_have_pred <= 1'b1;
                if (r_nskip != '0) begin
                    r_nskip <= r_nskip - 9'd1;
                end
            end else if (r_mark_hit) begin
                r_nskip <= r_nskip + 9'd1;
            end
        end
        if (i_cmd.upd || i_cmd.skip_pred) begin
            r_j      <= r_j - 32'd1;
            r_j_slot <= slot_dec(r_j_slot);
            r_left   <= r_left - CW'(1);
        end
        if (i_cmd.peak_chk) begin
            r_peak <= (w_rd_entry.peak > r_max_f) ? w_rd_entry.peak : r_max_f;
        end
        if (i_cmd.commit) begin
            r_out.chain_score <= r_max_f;
            r_out.predecessor <= r_have_pred ? r_max_j : 32'hffffffff;
            r_out.peak_score  <= r_have_pred ? r_peak : r_max_f;
        end
    end

    assign o_sts.st_at_i   = r_st == r_i;
    assign o_sts.walk_go   = {1'b0, r_item.ref_pos} > w_ref_reach;
    assign o_sts.scan_done = r_left == '0;
    assign o_sts.pass      = r_pass;
    assign o_sts.brk       = w_brk;
    assign o_sts.have_pred = r_have_pred;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

@@ rtl/anchor_chaining_dp.sv @@
// Items are taken one at a time: load, depth clamp, a walk that retires entries beyond the
// reference gap, the iteration-limit clamp, then a scan of predecessors from the newest. Each
// is read and put through the gap and band checks; one that passes is scored by a multiply,
// the radix-256 linear cost divider, cost, sum and update. The scan ends at the window start
// or on the skip limit, the best predecessor's peak is read, and the item commits when the
// output is free. Synchronous active-low reset restores defaults, empties window.
module anchor_chaining_dp #(
    parameter int WINDOW_DEPTH = acdp_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  acdp_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output acdp_pkg::t_out_item         o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [acdp_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import acdp_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    acdp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    acdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    acdp_dp #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );
endmodule

@@ sim/anchor_chaining_dp_test.sv @@
`timescale 1ns / 100ps

module anchor_chaining_dp_test;
    import acdp_pkg::*;

    localparam int DEPTH = WINDOW_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 2000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    anchor_chaining_dp dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // chaining state mirror
    t_cfg        cfg;
    logic [31:0] w_ref[DEPTH];
    logic [31:0] w_qry[DEPTH];
    logic [7:0]  w_seg[DEPTH];
    logic signed [31:0] w_score[DEPTH];
    logic [31:0] w_pred[DEPTH];
    logic        w_pvalid[DEPTH];
    logic signed [31:0] w_peak[DEPTH];
    logic [31:0] w_mark[DEPTH];
    logic [31:0] anchor_idx, win_first, cur_tag;

    t_out_item   expected_chains[$];
    int          mismatches;
    int          results_seen;
    int          items_sent;
    longint      cycles;
    bit          stall_out_enable;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint log2_floor(logic [31:0] v);
        longint r;
        r = 0;
        while (v > 1) begin
            v = v >> 1;
            r++;
        end
        return r;
    endfunction

    function automatic void reset_chain_state();
        cfg = '{max_ref_gap: 16'd5000, max_query_gap: 16'd5000, band_width: 16'd500,
                skip_limit: 8'd25, iter_limit: 7'd64, splice_mode: 1'b0,
                multi_segment: 1'b0, avg_span_q8: 16'd3840};
        for (int k = 0; k < DEPTH; k++) begin
            w_mark[k] = '0;
            w_pvalid[k] = 1'b0;
        end
        anchor_idx = '0;
        win_first = '0;
        cur_tag = '0;
    endfunction

    function automatic t_out_item chain_anchor(t_in_item a);
        logic [31:0] i, st, lim, n, j, pj, dd;
        int sj;
        longint ri, qi, qspan, max_f, n_skip, peak, dr, dq, diff, min_d, sc, c_lin, c_log;
        bit have_pred, same;
        logic [31:0] max_j;
        t_out_item r;
        ri = longint'(a.ref_pos);
        qi = longint'(a.query_pos);
        qspan = longint'(a.span);
        max_f = qspan;
        n_skip = 0;
        have_pred = 0;
        max_j = '0;
        if (a.read_start) begin
            anchor_idx = '0;
            win_first = '0;
            cur_tag = a.ref_tag;
        end else if (a.ref_tag != cur_tag) begin
            win_first = anchor_idx;
            cur_tag = a.ref_tag;
        end
        i = anchor_idx;
        st = win_first;
        if (i - st > DEPTH) st = i - DEPTH;
        while (st != i && ri > longint'(w_ref[st % DEPTH]) + longint'(cfg.max_ref_gap))
            st++;
        lim = (cfg.iter_limit < DEPTH) ? 32'(cfg.iter_limit) : DEPTH;
        if (i - st > lim) st = i - lim;
        n = i - st;
        for (longint k = 1; k <= n; k++) begin
            j = i - 32'(k);
            sj = j % DEPTH;
            same = (w_seg[sj] == a.segment_id);
            dr = ri - longint'(w_ref[sj]);
            dq = qi - longint'(w_qry[sj]);
            if ((same && dr == 0) || dq <= 0) continue;
            if ((same && dq > longint'(cfg.max_query_gap)) || dq > longint'(cfg.max_ref_gap))
                continue;
            diff = dr > dq ? dr - dq : dq - dr;
            dd = diff > 64'hFFFFFFFF ? 32'hFFFFFFFF : 32'(diff);
            if (same && dd > cfg.band_width) continue;
            if (cfg.multi_segment && !cfg.splice_mode && same
                && dr > longint'(cfg.max_query_gap)) continue;
            min_d = dq < dr ? dq : dr;
            sc = min_d > qspan ? qspan : min_d;
            c_log = dd != 0 ? log2_floor(dd) : 0;
            c_lin = longint'((64'(dd) * 64'(cfg.avg_span_q8)) / 64'd25600);
            if (cfg.splice_mode || !same) begin
                if (!same && dr == 0) sc += 1;
                else if (dr > dq || !same) sc -= (c_lin < c_log ? c_lin : c_log);
                else sc -= c_lin + (c_log >>> 1);
            end else begin
                sc -= c_lin + (c_log >>> 1);
            end
            sc = sat32(sc + longint'(w_score[sj]));
            if (sc > max_f) begin
                max_f = sc;
                max_j = j;
                have_pred = 1;
                if (n_skip > 0) n_skip--;
            end else if (w_mark[sj] == i) begin
                n_skip++;
                if (n_skip > longint'(cfg.skip_limit)) break;
            end
            if (w_pvalid[sj]) begin
                pj = w_pred[sj];
                if (i - pj <= n) w_mark[pj % DEPTH] = i;
            end
        end
        peak = max_f;
        if (have_pred && longint'(w_peak[max_j % DEPTH]) > max_f)
            peak = longint'(w_peak[max_j % DEPTH]);
        sj = i % DEPTH;
        w_ref[sj] = a.ref_pos;
        w_qry[sj] = {1'b0, a.query_pos};
        w_seg[sj] = a.segment_id;
        w_score[sj] = 32'(max_f);
        w_pred[sj] = max_j;
        w_pvalid[sj] = have_pred;
        w_peak[sj] = 32'(peak);
        w_mark[sj] = '0;
        anchor_idx = i + 1;
        win_first = st;
        r.chain_score = 32'(max_f);
        r.predecessor = have_pred ? max_j : 32'hFFFFFFFF;
        r.peak_score = 32'(peak);
        return r;
    endfunction

    // result checker with random output stalls
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_chains.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %h", o_out_data);
            end else begin
                exp_r = expected_chains.pop_front();
                if (o_out_data.chain_score !== exp_r.chain_score
                    || o_out_data.predecessor !== exp_r.predecessor
                    || o_out_data.peak_score !== exp_r.peak_score) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result %0d: expected score %0d pred %0d peak %0d, got %0d %0d %0d",
                                 results_seen, exp_r.chain_score, exp_r.predecessor,
                                 exp_r.peak_score, o_out_data.chain_score,
                                 o_out_data.predecessor, o_out_data.peak_score);
                end
            end
        end
    end

    int out_hold;
    always @(posedge i_clk) begin
        if (!stall_out_enable) begin
            i_out_ready <= 1'b1;
        end else if (out_hold > 0) begin
            out_hold <= out_hold - 1;
            if (out_hold == 1) i_out_ready <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            out_hold <= $urandom_range(1, 15);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // valid stays high into the next item unless an idle gap drops it
    task automatic send_anchor(t_in_item a, bit idle_gaps);
        int gap;
        if (idle_gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        expected_chains.push_back(chain_anchor(a));
        i_in_data <= a;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_chains.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= CFG_AW'(idx) << 2;
        pwdata <= value;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_MAX_REF_GAP:   cfg.max_ref_gap = value[15:0];
            REG_MAX_QUERY_GAP: cfg.max_query_gap = value[15:0];
            REG_BAND_WIDTH:    cfg.band_width = value[15:0];
            REG_SKIP_LIMIT:    cfg.skip_limit = value[7:0];
            REG_ITER_LIMIT:    cfg.iter_limit = value[6:0];
            REG_SPLICE_MODE:   cfg.splice_mode = value[0];
            REG_MULTI_SEGMENT: cfg.multi_segment = value[0];
            REG_AVG_SPAN_Q8:   cfg.avg_span_q8 = value[15:0];
            default: ;
        endcase
    endtask

    function automatic t_in_item make_anchor(bit start, logic [31:0] tag, logic [31:0] rpos,
                                             logic [30:0] qpos, logic [7:0] span,
                                             logic [7:0] seg);
        t_in_item a;
        a.read_start = start;
        a.ref_tag = tag;
        a.ref_pos = rpos;
        a.query_pos = qpos;
        a.span = span;
        a.segment_id = seg;
        return a;
    endfunction

    // a read of mostly collinear anchors with jitter, plus some noise
    task automatic send_read(int count, bit idle_gaps);
        logic [31:0] tag, rpos;
        logic [30:0] qpos;
        logic [7:0] seg;
        tag = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3);
        rpos = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 100000);
        qpos = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 50000));
        seg = 8'($urandom_range(0, 2));
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 19))
                0: tag = tag + 1;
                1: rpos = rpos - $urandom_range(0, 300);
                2: qpos = 31'($urandom);
                3: seg = 8'($urandom);
                4: rpos = rpos + $urandom_range(4000, 70000);
                default: begin
                    rpos = rpos + $urandom_range(0, 200);
                    qpos = qpos + 31'($urandom_range(0, 200)) - 31'($urandom_range(0, 20));
                end
            endcase
            send_anchor(make_anchor(k == 0, tag, rpos, qpos, 8'($urandom), seg), idle_gaps);
        end
    endtask

    task automatic test_directed();
        send_anchor(make_anchor(1, 32'd0, 32'd0, 31'd0, 8'd0, 8'd0), 0);
        send_anchor(make_anchor(0, 32'd0, 32'd100, 31'd100, 8'd255, 8'd0), 0);
        send_anchor(make_anchor(0, 32'd0, 32'd100, 31'd150, 8'd20, 8'd0), 0);
        send_anchor(make_anchor(0, 32'd0, 32'd100, 31'd200, 8'd20, 8'd1), 0);
        send_anchor(make_anchor(0, 32'd0, 32'd50, 31'd260, 8'd30, 8'd1), 0);
        send_anchor(make_anchor(0, 32'd0, 32'd400, 31'd380, 8'd30, 8'd1), 0);
        send_anchor(make_anchor(0, 32'hFFFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF, 8'd255,
                                8'hFF), 0);
        send_anchor(make_anchor(0, 32'hFFFFFFFF, 32'hFFFFFF00, 31'h7FFFFFF0, 8'd1, 8'hFF), 0);
        send_anchor(make_anchor(0, 32'hFFFFFFFF, 32'd0, 31'h7FFFFFFF, 8'd10, 8'h00), 0);
        send_anchor(make_anchor(1, 32'h5, 32'd1000, 31'd1000, 8'd15, 8'd0), 0);
        for (int k = 1; k < 80; k++)
            send_anchor(make_anchor(0, 32'h5, 32'd1000 + 32'(k * 15), 31'd1000 + 31'(k * 15),
                                    8'd15, 8'd0), 0);
        drain();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_MAX_REF_GAP, 32'd0);
        write_reg(REG_MAX_QUERY_GAP, 32'd0);
        write_reg(REG_BAND_WIDTH, 32'd0);
        write_reg(REG_SKIP_LIMIT, 32'd0);
        write_reg(REG_ITER_LIMIT, 32'd1);
        write_reg(REG_SPLICE_MODE, 32'd1);
        write_reg(REG_MULTI_SEGMENT, 32'd1);
        write_reg(REG_AVG_SPAN_Q8, 32'd0);
        send_read(30, 1);
        drain();
        write_reg(REG_MAX_REF_GAP, 32'd65535);
        write_reg(REG_MAX_QUERY_GAP, 32'd65535);
        write_reg(REG_BAND_WIDTH, 32'd65535);
        write_reg(REG_SKIP_LIMIT, 32'd255);
        write_reg(REG_ITER_LIMIT, 32'd64);
        write_reg(REG_SPLICE_MODE, 32'd0);
        write_reg(REG_AVG_SPAN_Q8, 32'd65535);
        send_read(40, 1);
        drain();
    endtask

    task automatic test_random_reads();
        for (int r = 0; r < 6; r++) begin
            write_reg(REG_MAX_REF_GAP, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(100, 6000));
            write_reg(REG_MAX_QUERY_GAP, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(100, 6000));
            write_reg(REG_BAND_WIDTH, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 600));
            write_reg(REG_SKIP_LIMIT, $urandom_range(0, 30));
            write_reg(REG_ITER_LIMIT, $urandom_range(1, 64));
            write_reg(REG_SPLICE_MODE, $urandom_range(0, 1));
            write_reg(REG_MULTI_SEGMENT, $urandom_range(0, 1));
            write_reg(REG_AVG_SPAN_Q8, $urandom);
            if (r == 5) stall_out_enable = 0;
            for (int k = 0; k < 3; k++) send_read($urandom_range(5, 30), r < 5);
            drain();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b1;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cycles = 0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        out_hold = 0;
        stall_out_enable = 1;
        reset_chain_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_register_extremes();
        test_random_reads();
        $display("Sent %0d anchors, checked %0d chain results across", items_sent, results_seen);
        $display("directed, register-extreme and random-read phases");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d mismatching results", mismatches);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ anchor_chaining_dp.f @@
rtl/acdp_pkg.sv
rtl/acdp_ram.sv
rtl/acdp_regs.sv
rtl/acdp_ctrl.sv
rtl/acdp_dp.sv
rtl/anchor_chaining_dp.sv
sim/anchor_chaining_dp_test.sv
